// File: design/jse_pkg.sv
package jse_pkg;

  // Width of one string byte and of the capacity register.
  localparam int ByteW = 8;
  localparam int CountW = 16;

  // Reset value of the output capacity register.
  localparam logic [CountW-1:0] CapacityReset = 16'd256;

  // Queue between the classifier and the expander.
  localparam int QueueDepth = 4;
  localparam int QueuePtrW = $clog2(QueueDepth);
  localparam int QueueCntW = $clog2(QueueDepth + 1);
  localparam logic [QueueCntW-1:0] QueueFull = QueueCntW'(QueueDepth);

  // Step counter inside one escape sequence; the longest is six bytes.
  localparam int StepW = 3;

  // Characters that take part in escapes.
  localparam logic [ByteW-1:0] ChNul       = 8'h00;
  localparam logic [ByteW-1:0] ChTab       = 8'h09;
  localparam logic [ByteW-1:0] ChNewline   = 8'h0A;
  localparam logic [ByteW-1:0] ChReturn    = 8'h0D;
  localparam logic [ByteW-1:0] ChSpace     = 8'h20;
  localparam logic [ByteW-1:0] ChQuote     = 8'h22;
  localparam logic [ByteW-1:0] ChZero      = 8'h30;
  localparam logic [ByteW-1:0] ChBackslash = 8'h5C;
  localparam logic [ByteW-1:0] ChLowerA    = 8'h61;
  localparam logic [ByteW-1:0] ChLowerN    = 8'h6E;
  localparam logic [ByteW-1:0] ChLowerR    = 8'h72;
  localparam logic [ByteW-1:0] ChLowerT    = 8'h74;
  localparam logic [ByteW-1:0] ChLowerU    = 8'h75;

  // How a queued byte is expanded.
  typedef enum logic [1:0] {
    KIND_PLAIN,    // one byte as is (also the terminator)
    KIND_SHORT,    // backslash and one letter
    KIND_UNICODE   // backslash, u, two zeros, two hex digits
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [ByteW-1:0] value;
  } entry_t;

  // Number of bytes an expansion produces.
  function automatic logic [StepW-1:0] kind_len(input kind_t kind);
    logic [StepW-1:0] len;
    case (kind)
      KIND_PLAIN:   len = 3'd1;
      KIND_SHORT:   len = 3'd2;
      KIND_UNICODE: len = 3'd6;
      default:      len = 3'd1;
    endcase
    return len;
  endfunction

  // Letter that follows the backslash in a two-byte escape.
  function automatic logic [ByteW-1:0] esc_letter(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] letter;
    case (c)
      ChNewline: letter = ChLowerN;
      ChReturn:  letter = ChLowerR;
      ChTab:     letter = ChLowerT;
      default:   letter = c;  // quote and backslash repeat themselves
    endcase
    return letter;
  endfunction

  // Lower-case hex digit for one nibble.
  function automatic logic [ByteW-1:0] hex_digit(input logic [3:0] v);
    logic [ByteW-1:0] d;
    if (v < 4'd10) begin
      d = ChZero + {4'h0, v};
    end else begin
      d = ChLowerA + {4'h0, v} - 8'd10;
    end
    return d;
  endfunction

endpackage

// File: design/jse_front.sv
module jse_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [jse_pkg::CountW-1:0] cfg_data,
  input  logic                       push,
  input  logic [jse_pkg::ByteW-1:0]  in_byte,
  input  logic                       q_full,
  output logic                       q_push,
  output jse_pkg::entry_t            q_data
);
  import jse_pkg::*;

  logic [CountW-1:0] capacity;
  logic [CountW-1:0] written_count;
  logic [CountW-1:0] written_count_next;
  logic              halted;
  logic              halted_next;
  logic              accept;
  logic              is_term;
  kind_t             kind;
  logic [StepW-1:0]  len;
  logic [CountW+1:0] need;
  logic              fits;
  logic              emit;

  assign accept = push && !q_full;
  assign is_term = (in_byte == ChNul);

  always_comb begin
    if (in_byte inside {ChQuote, ChBackslash, ChNewline, ChReturn, ChTab}) begin
      kind = KIND_SHORT;
    end else if (in_byte < ChSpace && !is_term) begin
      kind = KIND_UNICODE;
    end else begin
      kind = KIND_PLAIN;
    end
  end

  // The byte fits when the count plus its expansion still leaves the terminator room.
  assign len  = kind_len(kind);
  assign need = {2'b00, written_count} + (CountW+2)'(len) + (CountW+2)'(1);
  assign fits = (need <= {2'b00, capacity});
  assign emit = is_term || (!halted && fits);

  always_comb begin
    written_count_next = written_count;
    halted_next = halted;
    if (accept) begin
      if (is_term) begin
        written_count_next = '0;
        halted_next = 1'b0;
      end else if (emit) begin
        written_count_next = written_count + CountW'(len);
      end else begin
        halted_next = 1'b1;
      end
    end
  end

  assign q_push = accept && emit;
  assign q_data = '{kind: kind, value: in_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CapacityReset;
      written_count <= '0;
      halted <= 1'b0;
    end else begin
      if (cfg_write) begin
        capacity <= cfg_data;
      end
      written_count <= written_count_next;
      halted <= halted_next;
    end
  end

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && is_term) |=> (written_count == '0 && !halted))
    else $error("terminator did not clear count and halt");

  a_halt_no_push: assert property (@(posedge clk) disable iff (rst)
    (halted && !is_term) |-> !q_push)
    else $error("byte queued while output is halted");

endmodule

// File: design/jse_fifo.sv
module jse_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  jse_pkg::entry_t wdata,
  output logic            full,
  input  logic            pop,
  output jse_pkg::entry_t rdata,
  output logic            empty
);
  import jse_pkg::*;

  entry_t                slots [QueueDepth];
  logic [QueuePtrW-1:0]  wptr;
  logic [QueuePtrW-1:0]  rptr;
  logic [QueueCntW-1:0]  count;
  logic                  do_push;
  logic                  do_pop;

  // Full looks only at the count, so the pop side never reaches the push side.
  assign full    = (count == QueueFull);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + QueuePtrW'(1);
      end
      if (do_pop) begin
        rptr <= rptr + QueuePtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QueueCntW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QueueFull)
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == QueueFull) |-> (wptr == rptr))
    else $error("queue pointers disagree with count");

endmodule

// File: design/jse_back.sv
module jse_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  input  jse_pkg::entry_t           q_data,
  output logic                      q_pop,
  output logic                      empty,
  input  logic                      pop,
  output logic [jse_pkg::ByteW-1:0] out_byte,
  output logic                      out_last
);
  import jse_pkg::*;

  logic [StepW-1:0] step;
  logic [StepW-1:0] step_next;
  logic [StepW-1:0] len;
  logic             out_valid;
  logic             out_valid_next;
  logic             load;
  logic [ByteW-1:0] sel_byte;
  logic             sel_last;

  assign len  = kind_len(q_data.kind);
  assign load = !q_empty && (!out_valid || pop);

  always_comb begin
    case (q_data.kind)
      KIND_PLAIN: begin
        sel_byte = q_data.value;
      end
      KIND_SHORT: begin
        sel_byte = (step == '0) ? ChBackslash : esc_letter(q_data.value);
      end
      KIND_UNICODE: begin
        case (step)
          3'd0:       sel_byte = ChBackslash;
          3'd1:       sel_byte = ChLowerU;
          3'd2, 3'd3: sel_byte = ChZero;
          3'd4:       sel_byte = hex_digit(q_data.value[7:4]);
          default:    sel_byte = hex_digit(q_data.value[3:0]);
        endcase
      end
      default: begin
        sel_byte = q_data.value;
      end
    endcase
    sel_last = (step == len - StepW'(1));
  end

  always_comb begin
    step_next = step;
    q_pop = 1'b0;
    if (load) begin
      if (sel_last) begin
        step_next = '0;
        q_pop = 1'b1;
      end else begin
        step_next = step + StepW'(1);
      end
    end
  end

  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else if (pop) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= sel_byte;
      out_last <= sel_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      out_valid <= out_valid_next;
    end
  end

  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> (step == '0))
    else $error("expansion step left over with nothing queued");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> (step < len))
    else $error("expansion step beyond sequence length");

endmodule

// File: design/json_string_escaper.sv
// JSON string escaper.
// Input channel: the string arrives one byte per item on in_byte; an item is
// taken at a clock edge with push high and full low. A zero byte ends the
// string and always yields one zero output item with out_last set.
// Output channel: while empty is low, the oldest result sits on out_byte and
// out_last; it is taken at a clock edge with pop high. out_last marks the final
// output item produced by one input item.
// Configuration: cfg_write with cfg_data sets the output capacity (bytes,
// including the terminator); change it only while the block is idle.
// Path: a taken input item is written into the queue, then its results pass
// through the output register, from which they are popped.
// Throughput: one input item per cycle for plain text while full is low. The
// expander emits one output item per cycle while the receiver pops, so a
// two-byte escape occupies it for two output items and a unicode escape for
// six; a four-entry queue between classifier and expander absorbs short bursts
// of escapes before full rises. Bytes dropped for lack of room produce nothing.
// Reset clears the running count, the halt flag, the queue and the output
// register, and sets the capacity to 256. When the receiver stalls, the output
// register holds its item, the queue fills, and full rises; nothing is lost.
module json_string_escaper (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [jse_pkg::CountW-1:0] cfg_data,
  input  logic                       push,
  output logic                       full,
  input  logic [jse_pkg::ByteW-1:0]  in_byte,
  output logic                       empty,
  input  logic                       pop,
  output logic [jse_pkg::ByteW-1:0]  out_byte,
  output logic                       out_last
);
  import jse_pkg::*;

  // Classified bytes flow from the front end into the queue.
  logic   q_push;
  entry_t q_wdata;
  logic   q_full;

  // The expander drains the queue one output item at a time.
  logic   q_pop;
  entry_t q_rdata;
  logic   q_empty;

  // Input is accepted whenever the queue has room; the capacity decision
  // is made at accept time, so output stalls never change which bytes drop.
  assign full = q_full;

  // The front end owns the capacity register, the running count and the halt
  // flag, and queues only bytes that will actually be emitted.
  jse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .push      (push),
    .in_byte   (in_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  jse_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // The back end walks each queued entry through its escape sequence and
  // keeps the output register, which separates it from the receiver.
  jse_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_last (out_last)
  );

endmodule

// File: sim/tb_json_string_escaper.sv
module tb_json_string_escaper;
  import jse_pkg::*;

  // The run is bounded by this many clock cycles. The slowest correct run has
  // roughly 500 items with up to six results each, every result waiting out
  // the longest receiver stall, and this limit leaves a wide margin over that.
  localparam int CycleLimit = 600000;
  // Number of random input items to send after the directed part.
  localparam int RandomItems = 450;
  // Cycles to let pass once nothing is expected any more. The block has an
  // output register plus a short queue, and a dropped byte gives no result
  // that would tell us it is gone.
  localparam int DrainCycles = 12;

  // One escaped output character as the block presents it.
  typedef struct packed {
    logic [ByteW-1:0] ch;
    logic             last;
  } esc_char_t;

  // All inputs start at known values. Reset is high from time zero.
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [CountW-1:0] cfg_data = '0;
  logic              push = 1'b0;
  logic [ByteW-1:0]  in_byte = '0;
  logic              pop = 1'b0;
  logic              full;
  logic              empty;
  logic [ByteW-1:0]  out_byte;
  logic              out_last;

  // String bytes waiting to be sent, and escaped characters waiting to come
  // out of the block, oldest first.
  logic [ByteW-1:0] string_bytes[$];
  esc_char_t        expected_chars[$];

  // Our own copy of the escaper state. Counts are kept in int so that the
  // room checks never wrap.
  int   model_capacity = int'(CapacityReset);
  int   model_count = 0;
  logic model_halted = 1'b0;

  // Idling controls. A steady side never idles during the current phase.
  logic send_steady = 1'b0;
  logic recv_steady = 1'b0;
  int   send_gap = 0;
  int   recv_stall = 0;

  int mismatches = 0;
  int cycle_count = 0;

  json_string_escaper DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .in_byte  (in_byte),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_last (out_last)
  );

  always #5 clk = ~clk;

  // Gap length for either side. Most gaps are zero or short, and a few are
  // long enough to back the queue up or to drain it completely.
  function automatic int pick_gap(input logic steady);
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Lower-case hex character for one nibble.
  function automatic logic [ByteW-1:0] nibble_char(input logic [3:0] v);
    if (v < 4'd10) begin
      return ChZero + ByteW'(v);
    end
    return ChLowerA + ByteW'(v) - 8'd10;
  endfunction

  // Predicts what one accepted string byte produces and queues the escaped
  // characters. The terminator always yields a single zero character and
  // starts a new string. Otherwise nothing is emitted while halted, and a
  // byte or escape that would leave no room for the terminator halts the
  // output instead of being written in part.
  task automatic escape_byte(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] seq[6];
    int               len;
    esc_char_t        item;
    if (c == ChNul) begin
      item.ch = ChNul;
      item.last = 1'b1;
      expected_chars.push_back(item);
      model_count = 0;
      model_halted = 1'b0;
      return;
    end
    if (model_halted) begin
      return;
    end
    if (model_count + 1 >= model_capacity) begin
      model_halted = 1'b1;
      return;
    end
    seq[0] = ChBackslash;
    case (c)
      ChQuote, ChBackslash: begin
        seq[1] = c;
        len = 2;
      end
      ChNewline: begin
        seq[1] = ChLowerN;
        len = 2;
      end
      ChReturn: begin
        seq[1] = ChLowerR;
        len = 2;
      end
      ChTab: begin
        seq[1] = ChLowerT;
        len = 2;
      end
      default: begin
        if (c < ChSpace) begin
          // Any other control character becomes a six-character unicode
          // escape with two leading zeros.
          seq[1] = ChLowerU;
          seq[2] = ChZero;
          seq[3] = ChZero;
          seq[4] = nibble_char(c[7:4]);
          seq[5] = nibble_char(c[3:0]);
          len = 6;
        end else begin
          seq[0] = c;
          len = 1;
        end
      end
    endcase
    if (len > 1 && model_count + len + 1 > model_capacity) begin
      model_halted = 1'b1;
      return;
    end
    for (int i = 0; i < len; i++) begin
      item.ch = seq[i];
      item.last = (i == len - 1);
      expected_chars.push_back(item);
    end
    model_count = (model_count + len) & 16'hFFFF;
  endtask

  // Driver. When the input slot is free (nothing offered, or the offered item
  // is taken at this edge), it either idles for the current gap or offers the
  // next pending byte. The predictor runs on each byte as it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      send_gap <= 0;
      model_capacity = int'(CapacityReset);
      model_count = 0;
      model_halted = 1'b0;
    end else if (!push || !full) begin
      if (push) begin
        escape_byte(in_byte);
      end
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        push <= 1'b0;
      end else if (string_bytes.size() != 0) begin
        push <= 1'b1;
        in_byte <= string_bytes.pop_front();
        send_gap <= pick_gap(send_steady);
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor. Every character taken from the block is checked field by field
  // against the oldest expected one. The pop line is stalled at random.
  always @(posedge clk) begin
    esc_char_t want;
    if (rst) begin
      pop <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected output, expected nothing, got byte %h last %b",
                   $time, out_byte, out_last);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (out_byte !== want.ch) begin
            $display("%0t: out_byte mismatch, expected %h, got %h",
                     $time, want.ch, out_byte);
            mismatches++;
          end
          if (out_last !== want.last) begin
            $display("%0t: out_last mismatch, expected %b, got %b",
                     $time, want.last, out_last);
            mismatches++;
          end
        end
      end
      if (recv_stall != 0) begin
        recv_stall <= recv_stall - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (pop && !empty) begin
          recv_stall <= pick_gap(recv_steady);
        end
      end
    end
  end

  // Watchdog. A run that hangs is a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Waits until every byte has been sent and every expected character has
  // come out, then lets the pipeline settle so that a byte dropped for lack
  // of room is surely gone before the capacity changes.
  task automatic wait_idle();
    while (string_bytes.size() != 0 || push || expected_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Writes the capacity register. The block must be idle when this runs.
  task automatic write_capacity(input logic [CountW-1:0] value);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    model_capacity = int'(value);
  endtask

  // A random string byte. Plain text dominates, but the escaped characters,
  // the other control characters and the high half all show up often.
  function automatic logic [ByteW-1:0] random_string_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      return ByteW'($urandom_range(32, 126));
    end
    if (roll < 65) begin
      case ($urandom_range(0, 4))
        0: return ChQuote;
        1: return ChBackslash;
        2: return ChNewline;
        3: return ChReturn;
        default: return ChTab;
      endcase
    end
    if (roll < 80) begin
      return ByteW'($urandom_range(1, 31));
    end
    return ByteW'($urandom_range(127, 255));
  endfunction

  initial begin
    // Every character class at the reset capacity: plain letter, the five
    // short escapes, unicode escapes with digit and letter nibbles, space,
    // DEL, the high half and the all-ones byte, then the terminator.
    logic [ByteW-1:0] classes[14] = '{8'h41, ChQuote, ChBackslash, ChNewline,
                                     ChReturn, ChTab, 8'h01, 8'h1F, 8'h1B,
                                     ChSpace, 8'h7F, 8'h80, 8'hFF, ChNul};
    int               random_items;
    int               phase_items;
    int               str_len;
    int               max_len;
    logic [CountW-1:0] cap;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (classes[i]) begin
      string_bytes.push_back(classes[i]);
    end

    // Capacity one leaves room only for the terminator, so the first byte
    // of a string already finds the buffer full.
    wait_idle();
    write_capacity(16'd1);
    string_bytes.push_back(8'h61);
    string_bytes.push_back(ChNul);

    // An escape that does not fit halts the output, a later byte is dropped
    // while halted, and the terminator still comes out.
    wait_idle();
    write_capacity(16'd3);
    string_bytes.push_back(8'h61);
    string_bytes.push_back(ChNewline);
    string_bytes.push_back(8'h62);
    string_bytes.push_back(ChNul);

    // A unicode escape that fits with one place to spare, a plain byte that uses
    // the last free place, and then a plain byte that finds the buffer full.
    wait_idle();
    write_capacity(16'd8);
    string_bytes.push_back(8'h01);
    string_bytes.push_back(8'h78);
    string_bytes.push_back(8'h79);
    string_bytes.push_back(ChNul);

    // Random phases. Each one picks a capacity, including both extremes, and
    // sends whole strings of random content. A few strings lack their
    // terminator, so they run into the next string.
    random_items = 0;
    while (random_items < RandomItems) begin
      wait_idle();
      if (random_items == 0) begin
        cap = 16'hFFFF;
      end else begin
        case ($urandom_range(0, 4))
          0: cap = 16'd1;
          1: cap = 16'hFFFF;
          2: cap = CountW'($urandom_range(2, 16));
          3: cap = CountW'($urandom_range(17, 120));
          default: cap = CountW'($urandom_range(1, 65535));
        endcase
      end
      write_capacity(cap);
      send_steady = ($urandom_range(0, 3) == 0);
      recv_steady = ($urandom_range(0, 3) == 0);
      // Small buffers get strings long enough to run out of room.
      max_len = (int'(cap) < 16) ? 2 * int'(cap) + 4 : 40;
      phase_items = 0;
      while (phase_items < 50) begin
        str_len = $urandom_range(0, max_len);
        repeat (str_len) string_bytes.push_back(random_string_byte());
        phase_items += str_len;
        if ($urandom_range(0, 9) != 0) begin
          string_bytes.push_back(ChNul);
          phase_items++;
        end
      end
      random_items += phase_items;
    end

    // Close the last string so that its terminator is checked too.
    string_bytes.push_back(ChNul);
    wait_idle();

    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
design/jse_pkg.sv
design/jse_front.sv
design/jse_fifo.sv
design/jse_back.sv
design/json_string_escaper.sv
sim/tb_json_string_escaper.sv
